// File: rtl/mvwm_pkg.sv
// Shared types and constants for the motion vector weighted mean block.
// Used by every module of the block; depends on nothing else.
package mvwm_pkg;

  localparam int VEC_W   = 8;
  localparam int COST_W  = 16;
  localparam int REG_W   = 8;
  localparam int WEIGHT_W = 8;
  localparam int SUM_W   = 32;
  localparam int DEN_W   = 20;
  localparam int OUT_W   = 13;
  localparam int CNT_W   = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W   = 2;
  localparam int LEVEL_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MB_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MB_ROWS    = 1'd1;

  localparam logic [REG_W-1:0] MB_COLUMNS_RESET = 8'd40;
  localparam logic [REG_W-1:0] MB_ROWS_RESET    = 8'd30;

  localparam logic [CNT_W-1:0] LAST_STEP = 5'd31;
  localparam logic [SUM_W-1:0] POS_LIMIT = 32'd4095;
  localparam logic [SUM_W-1:0] NEG_LIMIT = 32'd4096;
  localparam logic [OUT_W-1:0] OUT_MAX   = 13'h0FFF;
  localparam logic [OUT_W-1:0] OUT_MIN   = 13'h1000;

  // One word passed from the front end to the weighting pipeline.
  typedef struct packed {
    logic                     last;
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;
    logic [COST_W-1:0]        cost;
  } mv_item_t;

  // Request to start the end-of-frame divide.
  typedef struct packed {
    logic                     start;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic [DEN_W-1:0]         den;
  } div_req_t;

endpackage

// File: rtl/mvwm_front.sv
// Front end: accepts input words, tracks the raster position and keeps
// only the entries that contribute or that end a frame. Uses mvwm_pkg.
module mvwm_front #(
  parameter int unsigned COST_LIMIT = 2000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [7:0]             vec_x,
  input  logic signed [7:0]             vec_y,
  input  logic [15:0]                   match_cost,
  input  logic [mvwm_pkg::REG_W-1:0]    cols,
  input  logic [mvwm_pkg::REG_W-1:0]    rows,
  input  logic                          full,
  output logic                          push,
  output mvwm_pkg::mv_item_t            item
);
  import mvwm_pkg::*;

  logic [REG_W-1:0] column_pos;
  logic [REG_W-1:0] row_pos;
  logic             accept;
  logic             real_entry;
  logic             keep;
  logic             frame_end;

  assign in_ready   = !full;
  assign accept     = in_valid && !full;
  assign real_entry = column_pos < cols;
  assign keep       = real_entry && !(vec_x == '0 && vec_y == '0)
                      && (match_cost <= COST_W'(COST_LIMIT));
  assign frame_end  = !real_entry
                      && (({1'b0, row_pos} + 9'd1) >= {1'b0, rows});
  assign push       = accept && (keep || frame_end);

  assign item.last  = !real_entry;
  assign item.vec_x = vec_x;
  assign item.vec_y = vec_y;
  assign item.cost  = match_cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (accept) begin
      if (real_entry) begin
        column_pos <= column_pos + 8'd1;
      end else begin
        column_pos <= '0;
        if (frame_end) begin
          row_pos <= '0;
        end else begin
          row_pos <= row_pos + 8'd1;
        end
      end
    end
  end

endmodule

// File: rtl/mvwm_fifo.sv
// Short word queue between the front end and the weighting pipeline.
// Uses mvwm_pkg for the word type and the depth.
module mvwm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mvwm_pkg::mv_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output mvwm_pkg::mv_item_t  head_item
);
  import mvwm_pkg::*;

  mv_item_t           slots [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] level;
  logic               do_push;
  logic               do_pop;

  assign full       = level == LEVEL_W'(FIFO_DEPTH);
  assign head_valid = level != '0;
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (do_push && !do_pop) begin
        level <= level + 3'd1;
      end else if (do_pop && !do_push) begin
        level <= level - 3'd1;
      end
    end
  end

endmodule

// File: rtl/mvwm_back.sv
// Weighting pipeline: turns each kept word into a weight by reciprocal
// multiplication, accumulates weighted components and hands the sums to
// the divider at the end of a frame. Uses mvwm_pkg.
module mvwm_back #(
  parameter int unsigned COST_LIMIT = 2000
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  mvwm_pkg::mv_item_t          head_item,
  output logic                        pop,
  input  logic [mvwm_pkg::REG_W-1:0]  cols,
  input  logic [mvwm_pkg::REG_W-1:0]  rows,
  input  logic                        div_busy,
  output mvwm_pkg::div_req_t          div_req
);
  import mvwm_pkg::*;

  localparam int unsigned NUM_W = $clog2(511 * COST_LIMIT + 1);
  localparam int unsigned DEN   = 2 * COST_LIMIT;
  localparam int unsigned RECIP = (2 ** NUM_W) / DEN;
  localparam int unsigned PROD_W = 2 * NUM_W;

  logic advance;

  // Stage 0: numerator of the rounded weight.
  logic                    s0_valid;
  logic                    s0_last;
  logic signed [VEC_W-1:0] s0_x;
  logic signed [VEC_W-1:0] s0_y;
  logic [NUM_W-1:0]        s0_num;
  logic [NUM_W-1:0]        num_calc;

  // Stage 1: quotient estimate.
  logic                    s1_valid;
  logic                    s1_last;
  logic signed [VEC_W-1:0] s1_x;
  logic signed [VEC_W-1:0] s1_y;
  logic [NUM_W-1:0]        s1_num;
  logic [WEIGHT_W-1:0]     s1_q;
  logic [PROD_W-1:0]       recip_prod;

  // Stage 2: estimate times divisor.
  logic                    s2_valid;
  logic                    s2_last;
  logic signed [VEC_W-1:0] s2_x;
  logic signed [VEC_W-1:0] s2_y;
  logic [NUM_W-1:0]        s2_num;
  logic [WEIGHT_W-1:0]     s2_q;
  logic [NUM_W-1:0]        s2_qd;

  // Stage 3: corrected weight.
  logic                    s3_valid;
  logic                    s3_last;
  logic signed [VEC_W-1:0] s3_x;
  logic signed [VEC_W-1:0] s3_y;
  logic [WEIGHT_W-1:0]     s3_w;
  logic [NUM_W-1:0]        rem_calc;

  // Stage 4: weighted components.
  logic                    s4_valid;
  logic                    s4_last;
  logic signed [16:0]      s4_px;
  logic signed [16:0]      s4_py;

  logic signed [SUM_W-1:0] sum_horizontal;
  logic signed [SUM_W-1:0] sum_vertical;
  logic [15:0]             frame_size;

  assign advance = !(s4_valid && s4_last && div_busy);
  assign pop     = advance && head_valid;

  assign num_calc   = NUM_W'({head_item.cost, 9'b0}) - NUM_W'({head_item.cost, 1'b0})
                      + NUM_W'(COST_LIMIT);
  assign recip_prod = PROD_W'(s0_num) * PROD_W'(NUM_W'(RECIP));
  assign rem_calc   = s2_num - s2_qd;
  assign frame_size = cols * rows;

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_last <= head_item.last;
      s0_x    <= head_item.vec_x;
      s0_y    <= head_item.vec_y;
      s0_num  <= num_calc;

      s1_last <= s0_last;
      s1_x    <= s0_x;
      s1_y    <= s0_y;
      s1_num  <= s0_num;
      s1_q    <= recip_prod[NUM_W +: WEIGHT_W];

      s2_last <= s1_last;
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_num  <= s1_num;
      s2_q    <= s1_q;
      s2_qd   <= NUM_W'(s1_q * NUM_W'(DEN));

      s3_last <= s2_last;
      s3_x    <= s2_x;
      s3_y    <= s2_y;
      if (rem_calc >= NUM_W'(DEN)) begin
        s3_w <= s2_q + 8'd1;
      end else begin
        s3_w <= s2_q;
      end

      s4_last <= s3_last;
      s4_px   <= $signed({1'b0, s3_w}) * s3_x;
      s4_py   <= $signed({1'b0, s3_w}) * s3_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid       <= 1'b0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
      s4_valid       <= 1'b0;
      sum_horizontal <= '0;
      sum_vertical   <= '0;
    end else if (advance) begin
      s0_valid <= head_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (s4_valid) begin
        if (s4_last) begin
          sum_horizontal <= '0;
          sum_vertical   <= '0;
        end else begin
          sum_horizontal <= sum_horizontal + SUM_W'(s4_px);
          sum_vertical   <= sum_vertical + SUM_W'(s4_py);
        end
      end
    end
  end

  assign div_req.start = advance && s4_valid && s4_last;
  assign div_req.sum_x = sum_horizontal;
  assign div_req.sum_y = sum_vertical;
  assign div_req.den   = {1'b0, frame_size, 3'b000};

endmodule

// File: rtl/mvwm_div.sv
// End-of-frame divider: two restoring dividers that share one step count,
// followed by saturation and the result register. Uses mvwm_pkg.
module mvwm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  mvwm_pkg::div_req_t           req,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [12:0]           mean_x,
  output logic signed [12:0]           mean_y
);
  import mvwm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } div_state_t;

  div_state_t       state;
  logic [CNT_W-1:0] step;
  logic [DEN_W-1:0] den;
  logic             neg_x;
  logic             neg_y;
  logic [SUM_W-1:0] quo_x;
  logic [SUM_W-1:0] quo_y;
  logic [DEN_W-1:0] rem_x;
  logic [DEN_W-1:0] rem_y;
  logic [DEN_W:0]   trial_x;
  logic [DEN_W:0]   trial_y;
  logic             fit_x;
  logic             fit_y;

  function automatic logic [OUT_W-1:0] saturate(input logic neg, input logic [SUM_W-1:0] mag);
    logic [OUT_W-1:0] res;
    if (neg) begin
      res = (mag > NEG_LIMIT) ? OUT_MIN : OUT_W'(-mag[OUT_W-1:0]);
    end else begin
      res = (mag > POS_LIMIT) ? OUT_MAX : mag[OUT_W-1:0];
    end
    return res;
  endfunction

  assign trial_x = {rem_x, quo_x[SUM_W-1]};
  assign trial_y = {rem_y, quo_y[SUM_W-1]};
  assign fit_x   = trial_x >= {1'b0, den};
  assign fit_y   = trial_y >= {1'b0, den};

  assign busy      = state != ST_IDLE;
  assign out_valid = state == ST_DONE;
  assign mean_x    = saturate(neg_x, quo_x);
  assign mean_y    = saturate(neg_y, quo_y);

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.start) begin
          den   <= req.den;
          neg_x <= req.sum_x[SUM_W-1];
          neg_y <= req.sum_y[SUM_W-1];
          quo_x <= req.sum_x[SUM_W-1] ? -req.sum_x : req.sum_x;
          quo_y <= req.sum_y[SUM_W-1] ? -req.sum_y : req.sum_y;
          rem_x <= '0;
          rem_y <= '0;
        end
      end
      ST_RUN: begin
        rem_x <= fit_x ? DEN_W'(trial_x - {1'b0, den}) : trial_x[DEN_W-1:0];
        rem_y <= fit_y ? DEN_W'(trial_y - {1'b0, den}) : trial_y[DEN_W-1:0];
        quo_x <= {quo_x[SUM_W-2:0], fit_x};
        quo_y <= {quo_y[SUM_W-2:0], fit_y};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          step <= step + 5'd1;
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/motion_vector_weighted_mean.sv
// Top level of the motion vector weighted mean block: configuration
// registers, front end, word queue, weighting pipeline and divider.
// Depends on mvwm_pkg, mvwm_front, mvwm_fifo, mvwm_back and mvwm_div.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    vec_x, vec_y, match_cost
//   out      out_valid / out_ready  mean_x, mean_y
//   cfg      cfg_write              cfg_index, cfg_data
//
// An input word is taken every cycle while the four-word queue has room.
// Kept words pass a five-stage weighting pipeline; the end of a frame then
// starts a divide, one quotient bit per cycle, after which the result word
// is presented on the out channel.
// The next frame's end waits in the last pipeline stage while a divide runs
// or a result has not been taken; the words behind it stall as well.
// Reset is synchronous and clears positions, sums and all valid flags.
module motion_vector_weighted_mean #(
  parameter int unsigned COST_LIMIT = 2000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [7:0]   vec_x,
  input  logic signed [7:0]   vec_y,
  input  logic [15:0]         match_cost,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [12:0]  mean_x,
  output logic signed [12:0]  mean_y
);
  import mvwm_pkg::*;

  logic [REG_W-1:0] mb_columns;
  logic [REG_W-1:0] mb_rows;
  logic [REG_W-1:0] cols;
  logic [REG_W-1:0] rows;
  logic             full;
  logic             push;
  mv_item_t         push_item;
  logic             pop;
  logic             head_valid;
  mv_item_t         head_item;
  logic             div_busy;
  div_req_t         div_req;

  // A zero register counts as one.
  assign cols = (mb_columns == '0) ? 8'd1 : mb_columns;
  assign rows = (mb_rows == '0) ? 8'd1 : mb_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      mb_columns <= MB_COLUMNS_RESET;
      mb_rows    <= MB_ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MB_COLUMNS: mb_columns <= cfg_data;
        REG_MB_ROWS:    mb_rows    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mvwm_front #(
    .COST_LIMIT (COST_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .match_cost (match_cost),
    .cols       (cols),
    .rows       (rows),
    .full       (full),
    .push       (push),
    .item       (push_item)
  );

  mvwm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  mvwm_back #(
    .COST_LIMIT (COST_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .cols       (cols),
    .rows       (rows),
    .div_busy   (div_busy),
    .div_req    (div_req)
  );

  mvwm_div u_div (
    .clk        (clk),
    .rst        (rst),
    .req        (div_req),
    .busy       (div_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_x     (mean_x),
    .mean_y     (mean_y)
  );

endmodule
